// ===== design/shadow_call_stack_checker_core_defines.svh =====
// assertion macros used by the checker file
`ifndef SHADOW_CALL_STACK_CHECKER_CORE_DEFINES_SVH
`define SHADOW_CALL_STACK_CHECKER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define SCSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scsc check failed");

// next-cycle implication, sampled on clk_i, off while in reset
`define SCSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scsc check failed");

`endif

// ===== design/scsc_pkg.sv =====
package scsc_pkg;

  // default sizing
  localparam int unsigned STACK_DEPTH_DEF  = 1024;
  localparam int unsigned ADDRESS_BITS_DEF = 64;

  // fixed payload widths
  localparam int unsigned FIELD_W = 64;
  localparam int unsigned DEPTH_W = 11;

  // request kinds
  localparam logic FUNC_ENTRY = 1'b0;
  localparam logic FUNC_EXIT  = 1'b1;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CORRUPT  = 3'd1,
    ST_NOMATCH  = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_EMPTY    = 3'd4
  } scsc_status_e;

  // request payload
  typedef struct packed {
    logic               func;
    logic [FIELD_W-1:0] function_address;
    logic [FIELD_W-1:0] call_site_address;
    logic [FIELD_W-1:0] frame_address;
    logic [FIELD_W-1:0] frame_word;
  } scsc_req_t;

  // result payload
  typedef struct packed {
    scsc_status_e       status;
    logic [DEPTH_W-1:0] depth_after;
    logic [FIELD_W-1:0] reported_function;
    logic [FIELD_W-1:0] reported_call_site;
  } scsc_rsp_t;

  // compare flags of one stored entry against the pending request
  typedef struct packed {
    logic func_eq;
    logic frame_eq;
    logic word_eq;
  } scsc_match_t;

endpackage

// ===== design/scsc_ram.sv =====
module scsc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // one registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/scsc_entry_match.sv =====
module scsc_entry_match import scsc_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic [ADDRESS_BITS-1:0] ent_func_i,
  input  logic [ADDRESS_BITS-1:0] ent_frame_i,
  input  logic [FIELD_W-1:0]      ent_word_i,
  input  logic [ADDRESS_BITS-1:0] req_func_i,
  input  logic [ADDRESS_BITS-1:0] req_frame_i,
  input  logic [FIELD_W-1:0]      req_word_i,
  output scsc_match_t             match_o
);

  // equality of stored entry and pending request
  always_comb begin
    match_o.func_eq  = (ent_func_i == req_func_i);
    match_o.frame_eq = (ent_frame_i == req_frame_i);
    match_o.word_eq  = (ent_word_i == req_word_i);
  end

endmodule

// ===== design/shadow_call_stack_checker_core.sv =====
// push: result valid the cycle after acceptance
// pop: one ram read then the check of the top entry
// pop with function mismatch and resync on: entries are searched
//   downward, one entry per cycle through the single ram read port
// next request is taken once idle and the result register is free or draining
// reset clears the depth count and sets resync on; ram contents are not cleared
module shadow_call_stack_checker_core import scsc_pkg::*; #(
  parameter int unsigned STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  scsc_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output scsc_rsp_t out_rsp_o
);

  localparam int unsigned IdxW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW   = ADDRESS_BITS;
  localparam int unsigned EntW = 3 * AW + FIELD_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [AW-1:0]      func_q, func_d;
  logic [AW-1:0]      frame_q, frame_d;
  logic [FIELD_W-1:0] word_q, word_d;
  logic               resync_q;
  logic               out_valid_q, out_valid_d;
  scsc_rsp_t          out_q, out_d;

  logic               in_acc;
  logic               rd_en, wr_en;
  logic [IdxW-1:0]    rd_addr;
  logic [EntW-1:0]    wr_data, rd_data;
  logic [AW-1:0]      ent_func, ent_cs, ent_frame;
  logic [FIELD_W-1:0] ent_word;
  scsc_match_t        match;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  // entry layout: function, call site, frame, saved word
  assign wr_data = {in_req_i.function_address[AW-1:0], in_req_i.call_site_address[AW-1:0],
                    in_req_i.frame_address[AW-1:0], in_req_i.frame_word};
  assign ent_func  = rd_data[EntW-1 -: AW];
  assign ent_cs    = rd_data[EntW-AW-1 -: AW];
  assign ent_frame = rd_data[EntW-2*AW-1 -: AW];
  assign ent_word  = rd_data[FIELD_W-1:0];

  // stack storage; writes happen only on a push and reads only on a pop,
  // so the same entry is never read and written in one cycle
  scsc_ram #(
    .Width (EntW),
    .Depth (STACK_DEPTH)
  ) u_scsc_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  scsc_entry_match #(
    .ADDRESS_BITS (AW)
  ) u_scsc_entry_match (
    .ent_func_i  (ent_func),
    .ent_frame_i (ent_frame),
    .ent_word_i  (ent_word),
    .req_func_i  (func_q),
    .req_frame_i (frame_q),
    .req_word_i  (word_q),
    .match_o     (match)
  );

  // sequencer: push, top read, check, downward search
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    func_d      = func_q;
    frame_d     = frame_q;
    word_d      = word_q;
    rd_en       = 1'b0;
    rd_addr     = idx_q;
    wr_en       = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          func_d  = in_req_i.function_address[AW-1:0];
          frame_d = in_req_i.frame_address[AW-1:0];
          word_d  = in_req_i.frame_word;
          out_d.reported_function  = '0;
          out_d.reported_call_site = '0;
          if (in_req_i.func == FUNC_ENTRY) begin
            out_valid_d = 1'b1;
            if (cnt_q == CntW'(STACK_DEPTH)) begin
              out_d.status      = ST_OVERFLOW;
              out_d.depth_after = DEPTH_W'(cnt_q);
            end else begin
              wr_en             = 1'b1;
              cnt_d             = cnt_q + CntW'(1);
              out_d.status      = ST_OK;
              out_d.depth_after = DEPTH_W'(cnt_d);
            end
          end else if (cnt_q == '0) begin
            out_valid_d       = 1'b1;
            out_d.status      = ST_EMPTY;
            out_d.depth_after = DEPTH_W'(cnt_q);
          end else begin
            rd_en   = 1'b1;
            rd_addr = IdxW'(cnt_q - CntW'(1));
            idx_d   = rd_addr;
            state_d = S_CHECK;
          end
        end
      end

      S_CHECK, S_SEARCH: begin
        if ((state_q == S_CHECK && (match.func_eq || !resync_q)) ||
            (state_q == S_SEARCH && match.func_eq && match.frame_eq)) begin
          // checked entry found: cut and pop it
          cnt_d                    = CntW'(idx_q);
          out_valid_d              = 1'b1;
          out_d.status             = match.word_eq ? ST_OK : ST_CORRUPT;
          out_d.depth_after        = DEPTH_W'(idx_q);
          out_d.reported_function  = FIELD_W'(ent_func);
          out_d.reported_call_site = FIELD_W'(ent_cs);
          state_d                  = S_IDLE;
        end else if (idx_q == '0) begin
          // search ran off the bottom, stack left as it was
          out_valid_d              = 1'b1;
          out_d.status             = ST_NOMATCH;
          out_d.depth_after        = DEPTH_W'(cnt_q);
          out_d.reported_function  = '0;
          out_d.reported_call_site = '0;
          state_d                  = S_IDLE;
        end else begin
          // next entry down
          rd_en   = 1'b1;
          rd_addr = idx_q - IdxW'(1);
          idx_d   = rd_addr;
          state_d = S_SEARCH;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      resync_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        resync_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    func_q  <= func_d;
    frame_q <= frame_d;
    word_q  <= word_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ===== design/scsc_checker.sv =====
`include "shadow_call_stack_checker_core_defines.svh"

module scsc_checker import scsc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input scsc_rsp_t out_rsp_o
);

  // a stalled result holds
  `SCSC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o))

  // a request is only taken when the result register can take its result
  `SCSC_ASSERT_NOW(a_in_room, in_valid_i && in_ready_o, !out_valid_o || out_ready_i)

  // nomatch, overflow and empty results carry no entry
  `SCSC_ASSERT_NOW(a_err_zero, out_valid_o && (out_rsp_o.status == ST_NOMATCH ||
    out_rsp_o.status == ST_OVERFLOW || out_rsp_o.status == ST_EMPTY),
    out_rsp_o.reported_function == '0 && out_rsp_o.reported_call_site == '0)

  // overflow only on a full stack, empty only on an empty one
  `SCSC_ASSERT_NOW(a_bounds, out_valid_o && (out_rsp_o.status == ST_OVERFLOW ||
    out_rsp_o.status == ST_EMPTY), out_rsp_o.depth_after ==
    ((out_rsp_o.status == ST_OVERFLOW) ? DEPTH_W'(STACK_DEPTH) : '0))

endmodule

bind shadow_call_stack_checker_core scsc_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_scsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
